[rtl/core/rmsm_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed RMS meter package
// Field widths, register reset value and shared sizes for the RMS meter.
// ----------------------------------------------------------------------------
package rmsm_pkg;

  // Input sample: two's complement raw acceleration
  localparam int SAMPLE_W = 16;
  // Sample magnitude 0..32768
  localparam int MAG_W = 16;
  // Square of the magnitude, up to 2^30
  localparam int SQ_W = 31;
  // Result: floored RMS, 0..32768
  localparam int RMS_W = 16;

  // Window length register
  localparam int WLEN_W = 11;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd500;

  // Default largest window
  localparam int WINDOW_MAX_DEF = 1024;

endpackage

[rtl/core/rmsm_mean_root.sv]
// ----------------------------------------------------------------------------
// Mean and root unit
// Bit-serial restoring divide of the window sum by the sample count, then a
// two-bits-per-step restoring square root of the quotient.
// ----------------------------------------------------------------------------
module rmsm_mean_root #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        done,
  output logic [rmsm_pkg::RMS_W-1:0]  root
);

  localparam int SQ_STEPS = (SUM_W + 1) / 2;
  localparam int V_W      = 2 * SQ_STEPS;
  localparam int RS_W     = SQ_STEPS + 2;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_ROOT
  } ustate_t;

  ustate_t             state;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    dvsr;
  logic [CNT_W-1:0]    rem;
  logic [SUM_W-1:0]    quo;
  logic [V_W-1:0]      vsh;
  logic [RS_W-1:0]     rs;
  logic [SQ_STEPS-1:0] yr;

  // Divide step: shift in the next dividend bit, subtract if it fits
  logic [CNT_W:0]   r_sh;
  logic [CNT_W:0]   d_ext;
  logic [CNT_W:0]   r_diff;
  logic             div_ge;
  logic [CNT_W-1:0] rem_next;

  assign r_sh     = {rem, quo[SUM_W-1]};
  assign d_ext    = {1'b0, dvsr};
  assign div_ge   = (r_sh >= d_ext);
  assign r_diff   = r_sh - d_ext;
  assign rem_next = div_ge ? r_diff[CNT_W-1:0] : r_sh[CNT_W-1:0];

  // Root step: bring down two bits, try root*4+1
  logic [RS_W+1:0] rs_sh;
  logic [RS_W+1:0] trial;
  logic [RS_W+1:0] rs_diff;
  logic            sq_ge;
  logic [RS_W-1:0] rs_next;

  assign rs_sh   = {rs, vsh[V_W-1:V_W-2]};
  assign trial   = (RS_W+2)'({yr, 2'b01});
  assign sq_ge   = (rs_sh >= trial);
  assign rs_diff = rs_sh - trial;
  assign rs_next = sq_ge ? rs_diff[RS_W-1:0] : rs_sh[RS_W-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      // one-cycle pulse with the last root step
      done <= (state == U_ROOT) && (step == STEP_W'(SQ_STEPS - 1));
      unique case (state)
        U_IDLE: begin
          if (start) begin
            quo   <= dividend;
            rem   <= '0;
            dvsr  <= divisor;
            step  <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          rem  <= rem_next;
          quo  <= {quo[SUM_W-2:0], div_ge};
          if (step == STEP_W'(SUM_W - 1)) begin
            vsh   <= V_W'({quo[SUM_W-2:0], div_ge});
            rs    <= '0;
            yr    <= '0;
            step  <= '0;
            state <= U_ROOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        U_ROOT: begin
          rs   <= rs_next;
          yr   <= {yr[SQ_STEPS-2:0], sq_ge};
          vsh  <= {vsh[V_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_W'(SQ_STEPS - 1)) begin
            root  <= rmsm_pkg::RMS_W'({yr[SQ_STEPS-2:0], sq_ge});
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/windowed_rms_meter_top.sv]
// A sample is squared by the shift-add squarer before the next sample is taken. A
// window-ending sample is also divided and rooted by the serial unit before the next
// sample is taken; a full output register stalls that hand-off.
// Reset clears the window sum, sample count and output valid; window length is 500.
// ----------------------------------------------------------------------------
// Windowed RMS meter
// Accumulates squared samples over non-overlapping windows and emits the
// floored root of the floored mean square at each window end.
// ----------------------------------------------------------------------------
module windowed_rms_meter_top #(
  parameter int WINDOW_MAX = rmsm_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: window_length
  input  logic                          cfg_we,
  input  logic [rmsm_pkg::WLEN_W-1:0]   cfg_wdata,   // [10:0] window_length
  // Sample stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rmsm_pkg::SAMPLE_W-1:0] s_tdata,     // [15:0] sample
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rmsm_pkg::RMS_W-1:0]    m_tdata      // [15:0] rms_value
);

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = rmsm_pkg::SQ_W + $clog2(WINDOW_MAX);
  localparam int CMP_W  = (CNT_W > rmsm_pkg::WLEN_W) ? CNT_W : rmsm_pkg::WLEN_W;
  localparam int MAG_W  = rmsm_pkg::MAG_W;
  localparam int MD_W   = rmsm_pkg::SQ_W;
  localparam int BIT_W  = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_OUT
  } state_t;

  state_t                       state;
  logic [rmsm_pkg::WLEN_W-1:0]  window_length;
  logic [SUM_W-1:0]             square_sum;
  logic [CNT_W-1:0]             sample_count;
  logic [MD_W-1:0]              md;
  logic [MAG_W-1:0]             mq;
  logic [BIT_W-1:0]             bit_cnt;
  logic                         close;

  logic                         root_start;
  logic                         root_done;
  logic [rmsm_pkg::RMS_W-1:0]   root;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rmsm_pkg::WLEN_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // Effective length: zero acts as one, clamp at WINDOW_MAX
  logic [CMP_W-1:0] wl_ext;
  logic [CMP_W-1:0] eff_len;
  logic [CNT_W-1:0] cnt_inc;
  logic [MAG_W-1:0] mag;

  assign wl_ext = CMP_W'(window_length);

  always_comb begin
    priority if (wl_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      eff_len = CMP_W'(WINDOW_MAX);
    end else begin
      eff_len = wl_ext;
    end
  end

  assign cnt_inc = sample_count + 1'b1;

  // Magnitude of the two's complement sample
  assign mag = s_tdata[rmsm_pkg::SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;

  assign s_tready   = (state == ST_IDLE);
  assign root_start = (state == ST_START);

  // Control, shift-add squarer, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      square_sum   <= '0;
      sample_count <= '0;
      bit_cnt      <= '0;
      close        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // ST_OUT reloads the register itself
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            md           <= MD_W'(mag);
            mq           <= mag;
            bit_cnt      <= '0;
            sample_count <= cnt_inc;
            close        <= (CMP_W'(cnt_inc) >= eff_len);
            state        <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          // one multiplier bit per cycle, added straight into the window sum
          if (mq[0]) begin
            square_sum <= square_sum + SUM_W'(md);
          end
          md      <= {md[MD_W-2:0], 1'b0};
          mq      <= {1'b0, mq[MAG_W-1:1]};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(MAG_W - 1)) begin
            state <= close ? ST_START : ST_IDLE;
          end
        end
        ST_START: begin
          // unit has latched the sum and count; open a new window
          square_sum   <= '0;
          sample_count <= '0;
          state        <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= root;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rmsm_mean_root #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_mean_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .dividend (square_sum),
    .divisor  (sample_count),
    .done     (root_done),
    .root     (root)
  );

`ifndef SYNTH
  // count never runs past the largest window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(sample_count) <= CMP_W'(WINDOW_MAX))
    else $error("sample count beyond window max");

  // handing a window to the unit leaves an empty window behind
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |=> (square_sum == '0 && sample_count == '0))
    else $error("window not cleared after close");

  // the unit reports only while the controller waits on it
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == ST_ROOT))
    else $error("root done outside of root wait");

  // the root of a mean square of 16-bit samples stays within 32768
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (root <= rmsm_pkg::RMS_W'(32768)))
    else $error("root out of range");
`endif

endmodule

[dv/windowed_rms_meter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed RMS meter testbench
// Streams raw samples through the meter under several window lengths, tracks
// the window sum and count on the side, and checks every RMS item in order.
// ----------------------------------------------------------------------------
module windowed_rms_meter_top_tb;

  localparam int SAMPLE_W     = rmsm_pkg::SAMPLE_W;
  localparam int MAG_W        = rmsm_pkg::MAG_W;
  localparam int RMS_W        = rmsm_pkg::RMS_W;
  localparam int WLEN_W       = rmsm_pkg::WLEN_W;
  localparam logic [WLEN_W-1:0] WLEN_RESET = rmsm_pkg::WLEN_RESET;
  localparam int WMAX         = rmsm_pkg::WINDOW_MAX_DEF;
  localparam int ACC_W        = rmsm_pkg::SQ_W + WLEN_W - 1;   // 41 bits at WMAX = 1024
  localparam int DRAIN_CYCLES = 120;                 // window-end latency plus margin
  localparam int HOLD_CYCLES  = 600;
  localparam int GAP_MAX      = 13;
  localparam int MAX_REPORTS  = 10;

  // Extreme sample values, two's complement
  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [8] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
    16'h8000, 16'h8001, 16'h4000, 16'hC000
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [WLEN_W-1:0]   cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;   // [15:0] sample
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [RMS_W-1:0]    m_tdata;          // [15:0] rms_value

  windowed_rms_meter_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Pending samples and predicted RMS items
  logic [SAMPLE_W-1:0] sample_queue [$];
  logic [RMS_W-1:0]    rms_expected [$];

  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int tx_gap    = 0;
  int rx_gap    = 0;
  int fail_count = 0;

  // Shadow of the window register and the running window
  logic [WLEN_W-1:0] wlen_shadow = WLEN_RESET;
  logic [ACC_W-1:0]  sq_acc      = '0;
  logic [WLEN_W-1:0] cnt_acc     = '0;

  // Floor square root, one result bit per trial
  function automatic logic [RMS_W-1:0] floor_root(input logic [ACC_W-1:0] v);
    logic [RMS_W:0] r;
    logic [RMS_W:0] t;
    r = '0;
    for (int b = RMS_W; b >= 0; b--) begin
      t = r | ((RMS_W+1)'(1) << b);
      if ({17'd0, t} * {17'd0, t} <= v) r = t;
    end
    return r[RMS_W-1:0];
  endfunction

  // Add one sample to the window; close it when the count reaches the length
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [MAG_W:0]    mag;
    logic [WLEN_W-1:0] lim;
    mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    sq_acc  = sq_acc + mag * mag;
    cnt_acc = cnt_acc + 1'b1;
    if (wlen_shadow == '0) lim = WLEN_W'(1);
    else if (wlen_shadow > WMAX) lim = WLEN_W'(WMAX);
    else lim = wlen_shadow;
    if (cnt_acc >= lim) begin
      rms_expected.push_back(floor_root(sq_acc / cnt_acc));
      sq_acc  = '0;
      cnt_acc = '0;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] tiny;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: begin
        tiny = 16'($urandom_range(0, 31));
        return ($urandom_range(0, 1) != 0) ? ~tiny : tiny;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        s_tdata  <= sample_queue.pop_front();
        s_tvalid <= 1'b1;
        tx_gap = tx_calm ? 0 : int'($urandom_range(0, GAP_MAX));
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver: random wait after each item
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) rx_gap = rx_calm ? 0 : int'($urandom_range(0, GAP_MAX));
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap = rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare results, then track accepted samples and config
  always @(posedge clk) begin : check_results
    logic [RMS_W-1:0] want;
    if (rst) begin
      wlen_shadow = WLEN_RESET;
      sq_acc      = '0;
      cnt_acc     = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rms_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected rms item: got %0d", m_tdata);
        end else begin
          want = rms_expected.pop_front();
          if (m_tdata !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("rms mismatch: expected %0d, got %0d", want, m_tdata);
          end
        end
      end
      // a sample taken at this edge still sees the old length
      if (s_tvalid && s_tready) absorb_sample(s_tdata);
      if (cfg_we) wlen_shadow = cfg_wdata;
    end
  end

  // Sender pause: all samples taken, all results in, window-end work finished
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || rms_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [WLEN_W-1:0] len);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) sample_queue.push_back(random_sample());
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int len;
    int span;
    int n;
    int pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset length of 500: extremes open the window, random samples close it
    foreach (EDGE_SAMPLES[i]) sample_queue.push_back(EDGE_SAMPLES[i]);
    push_random(500 - 8);

    // Length 1: every sample gives its own magnitude
    set_window(11'd1);
    foreach (EDGE_SAMPLES[i]) sample_queue.push_back(EDGE_SAMPLES[i]);

    // Zero length acts as 1
    set_window(11'd0);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'hAAAA);

    // Shorten the window mid-way: next sample closes over all three
    set_window(11'd3);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    set_window(11'd2);
    sample_queue.push_back(16'h0001);

    // Receiver holds off while the sender keeps offering
    set_window(11'd1);
    tx_calm  = 1'b1;
    rx_calm  = 1'b0;
    hold_req = 1'b1;
    push_random(60);

    // Oversized length saturates; full-scale window gives the top result
    set_window(11'h7FF);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (WMAX) sample_queue.push_back(16'h8000);

    // Random lengths, some windows left open across a length change
    repeat (24) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) len = $urandom_range(1, 8);
      else if (pick < 17) len = $urandom_range(9, 32);
      else if (pick == 17) len = 0;
      else len = $urandom_range(WMAX + 1, 2047);
      set_window(WLEN_W'(len));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (len > WMAX) begin
        n = $urandom_range(1, 24);
      end else begin
        span = (len == 0) ? 1 : len;
        n = span * $urandom_range(1, 2);
        if ($urandom_range(0, 2) == 0) n += $urandom_range(0, span);
      end
      push_random(n);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[windowed_rms_meter_top.f]
rtl/core/rmsm_pkg.sv
rtl/core/rmsm_mean_root.sv
rtl/core/windowed_rms_meter_top.sv
dv/windowed_rms_meter_top_tb.sv
